### rtl/pils_pkg.sv
// ----------------------------------------------------------------------------
// Packed ID list store package
// Shared widths, operation and status codes, and the command that the
// controller broadcasts to every cell of the list.
// ----------------------------------------------------------------------------
package pils_pkg;

   localparam int CAPACITY = 256;
   localparam int IDX_W    = 8;
   localparam int CNT_W    = 9;
   localparam int ID_W     = 32;

   typedef enum logic [1:0] {
      ACT_APPEND = 2'd0,
      ACT_READ   = 2'd1,
      ACT_DELETE = 2'd2,
      ACT_CLEAR  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_RANGE     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_WRITE,
      CELL_MATCH,
      CELL_WAVE,
      CELL_SHIFT
   } cell_op_type;

   typedef struct packed {
      cell_op_type         op;
      logic [ID_W-1:0]     id;
      logic [IDX_W-1:0]    index;
      logic [CNT_W-1:0]    count;
   } cell_cmd_type;

endpackage

### rtl/pils_cell.sv
// ----------------------------------------------------------------------------
// Packed ID list cell
// Holds one list entry. Passes search flags, shifted entries and read data
// to its neighbors one position per cycle.
// ----------------------------------------------------------------------------
module pils_cell (
   input  logic                          clock,
   input  pils_pkg::cell_cmd_type        cmd,
   input  logic [pils_pkg::IDX_W-1:0]    cell_index,
   input  logic                          left_pre,
   input  logic                          right_suf,
   input  logic [pils_pkg::ID_W-1:0]     right_entry,
   input  logic [pils_pkg::ID_W-1:0]     right_rd,
   output logic [pils_pkg::ID_W-1:0]     entry,
   output logic                          pre,
   output logic                          suf,
   output logic [pils_pkg::ID_W-1:0]     rd
);
   import pils_pkg::*;

   logic [ID_W-1:0] entry_ff, entry_in;
   logic [ID_W-1:0] rd_ff, rd_in;
   logic            match_ff, match_in;
   logic            pre_ff, pre_in;
   logic            suf_ff, suf_in;
   logic            live;

   assign live = {1'b0, cell_index} < cmd.count;

   always_comb begin
      entry_in = entry_ff;
      match_in = match_ff;
      pre_in   = pre_ff;
      suf_in   = suf_ff;
      rd_in    = (cell_index == cmd.index) ? entry_ff : right_rd;
      case (cmd.op)
         CELL_WRITE: begin
            if (cell_index == cmd.count[IDX_W-1:0]) begin
               entry_in = cmd.id;
            end
         end
         CELL_MATCH: begin
            match_in = live && (entry_ff == cmd.id);
            pre_in   = 1'b0;
            suf_in   = 1'b0;
         end
         CELL_WAVE: begin
            pre_in = left_pre | match_ff;
            suf_in = right_suf | match_ff;
         end
         CELL_SHIFT: begin
            if (pre_ff) begin
               entry_in = right_entry;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      rd_ff    <= rd_in;
      match_ff <= match_in;
      pre_ff   <= pre_in;
      suf_ff   <= suf_in;
   end

   assign entry = entry_ff;
   assign pre   = pre_ff;
   assign suf   = suf_ff;
   assign rd    = rd_ff;

endmodule

### rtl/pils_ctrl.sv
// ----------------------------------------------------------------------------
// Packed ID list controller
// Sequences each operation over the cell row, keeps the live count and
// holds the result beat in an output register.
// ----------------------------------------------------------------------------
module pils_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [39:0]                   req_tdata,
   input  logic [1:0]                    req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [47:0]                   rsp_tdata,
   output logic [1:0]                    rsp_tuser,
   output pils_pkg::cell_cmd_type        cmd,
   input  logic                          found,
   input  logic [pils_pkg::ID_W-1:0]     rd_data
);
   import pils_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_APPEND,
      S_READ,
      S_MATCH,
      S_WAVE,
      S_FINISH
   } state_type;

   state_type        state_ff, state_in;
   logic [ID_W-1:0]  id_ff, id_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] step_ff, step_in;
   logic [ID_W-1:0]  res_id_ff, res_id_in;
   status_type       res_st_ff, res_st_in;
   logic             out_valid_ff, out_valid_in;
   logic [ID_W-1:0]  out_id_ff, out_id_in;
   logic [CNT_W-1:0] out_count_ff, out_count_in;
   status_type       out_st_ff, out_st_in;
   cell_op_type      op;
   logic             slot_free;

   assign req_tready = (state_ff == S_IDLE);
   assign slot_free  = !out_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      id_in        = id_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      res_id_in    = res_id_ff;
      res_st_in    = res_st_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_id_in    = out_id_ff;
      out_count_in = out_count_ff;
      out_st_in    = out_st_ff;
      op           = CELL_HOLD;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               id_in     = req_tdata[31:0];
               idx_in    = req_tdata[39:32];
               step_in   = '0;
               res_id_in = '0;
               res_st_in = ST_OK;
               case (action_type'(req_tuser))
                  ACT_APPEND: state_in = S_APPEND;
                  ACT_READ:   state_in = S_READ;
                  ACT_DELETE: state_in = S_MATCH;
                  default: begin
                     count_in = '0;
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_APPEND: begin
            if (count_ff < CNT_W'(CAPACITY)) begin
               op       = CELL_WRITE;
               count_in = count_ff + CNT_W'(1);
            end else begin
               res_st_in = ST_FULL;
            end
            state_in = S_FINISH;
         end
         S_READ: begin
            if ({1'b0, idx_ff} >= count_ff) begin
               res_st_in = ST_RANGE;
               state_in  = S_FINISH;
            end else if (step_ff == {1'b0, idx_ff} + CNT_W'(1)) begin
               res_id_in = rd_data;
               state_in  = S_FINISH;
            end else begin
               step_in = step_ff + CNT_W'(1);
            end
         end
         S_MATCH: begin
            op       = CELL_MATCH;
            state_in = S_WAVE;
         end
         S_WAVE: begin
            if (step_ff == count_ff) begin
               if (found) begin
                  op       = CELL_SHIFT;
                  count_in = count_ff - CNT_W'(1);
               end else begin
                  res_st_in = ST_NOT_FOUND;
               end
               state_in = S_FINISH;
            end else begin
               op      = CELL_WAVE;
               step_in = step_ff + CNT_W'(1);
            end
         end
         S_FINISH: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_id_in    = res_id_ff;
               out_count_in = count_ff;
               out_st_in    = res_st_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
      id_ff        <= id_in;
      idx_ff       <= idx_in;
      step_ff      <= step_in;
      res_id_ff    <= res_id_in;
      res_st_ff    <= res_st_in;
      out_id_ff    <= out_id_in;
      out_count_ff <= out_count_in;
      out_st_ff    <= out_st_in;
   end

   assign cmd.op    = op;
   assign cmd.id    = id_ff;
   assign cmd.index = idx_ff;
   assign cmd.count = count_ff;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_count_ff, out_id_ff};
   assign rsp_tuser  = out_st_ff;

endmodule

### rtl/packed_id_list_store_top.sv
// ----------------------------------------------------------------------------
// Packed ID list store
// A packed list of 32-bit IDs kept in a row of cells, with append, read at
// index, delete by value with shift down, and clear.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  req      in         tuser: action; tdata: id_value, entry_index
//  rsp      out        tuser: status; tdata: id_out, entry_count
//
//  Read data and the delete search travel one cell per cycle along the row.
//  Reset clears the count and the control state; entries need no clearing.
//  A new beat is taken while the previous result still waits on rsp.
// ----------------------------------------------------------------------------
module packed_id_list_store_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // id_value[31:0], entry_index[39:32]
   input  logic [1:0]  req_tuser,   // action[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // id_out[31:0], entry_count[40:32], zeros
   output logic [1:0]  rsp_tuser    // status[1:0]
);
   import pils_pkg::*;

   cell_cmd_type    cmd;
   logic [ID_W-1:0] entry_w [CAPACITY];
   logic [ID_W-1:0] rd_w    [CAPACITY];
   logic            pre_w   [CAPACITY];
   logic            suf_w   [CAPACITY];

   pils_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .found      (suf_w[0]),
      .rd_data    (rd_w[0])
   );

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic            left_pre;
      logic            right_suf;
      logic [ID_W-1:0] right_entry;
      logic [ID_W-1:0] right_rd;

      if (g == 0) begin : g_first
         assign left_pre = 1'b0;
      end else begin : g_mid
         assign left_pre = pre_w[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign right_suf   = 1'b0;
         assign right_entry = '0;
         assign right_rd    = '0;
      end else begin : g_inner
         assign right_suf   = suf_w[g+1];
         assign right_entry = entry_w[g+1];
         assign right_rd    = rd_w[g+1];
      end

      pils_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .cell_index  (IDX_W'(g)),
         .left_pre    (left_pre),
         .right_suf   (right_suf),
         .right_entry (right_entry),
         .right_rd    (right_rd),
         .entry       (entry_w[g]),
         .pre         (pre_w[g]),
         .suf         (suf_w[g]),
         .rd          (rd_w[g])
      );
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[40:32] <= CNT_W'(CAPACITY))
      else $error("result count beyond capacity");

   a_full_count : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ST_FULL) |-> rsp_tdata[40:32] == CNT_W'(CAPACITY))
      else $error("full status with list not full");

   a_zero_id : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != ST_OK) |-> rsp_tdata[31:0] == '0)
      else $error("nonzero id with failing status");

endmodule

### verif/list_store_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Packed ID list store checker
// Watches the request and response streams of the packed ID list store.
// Every accepted request beat updates a private copy of the list and its
// count, and queues the response that the block must return for it. Each
// accepted response beat is compared field by field with the oldest queued
// response. Mismatches and unexpected responses raise the failure count.
// ----------------------------------------------------------------------------
module list_store_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   output int          fail_count,
   output int          pending_count
);
   import pils_pkg::*;

   typedef struct packed {
      logic [ID_W-1:0]  id_out;
      logic [CNT_W-1:0] count;
      status_type       status;
   } list_rsp_type;

   logic [ID_W-1:0]  shadow_ids [CAPACITY];
   logic [CNT_W-1:0] shadow_len;
   list_rsp_type     awaited_rsp_q [$];

   task automatic apply_list_op(input action_type act, input logic [ID_W-1:0] id,
                                input logic [IDX_W-1:0] idx, output list_rsp_type r);
      int hit;
      r = '{id_out: '0, count: '0, status: ST_OK};
      hit = -1;
      case (act)
         ACT_APPEND: begin
            if (shadow_len >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               shadow_ids[shadow_len[IDX_W-1:0]] = id;
               shadow_len = shadow_len + 1'b1;
            end
         end
         ACT_READ: begin
            if (idx >= shadow_len) begin
               r.status = ST_RANGE;
            end else begin
               r.id_out = shadow_ids[idx];
            end
         end
         ACT_DELETE: begin
            for (int i = 0; i < shadow_len; i++) begin
               if (hit < 0 && shadow_ids[i] == id) begin
                  hit = i;
               end
            end
            if (hit < 0) begin
               r.status = ST_NOT_FOUND;
            end else begin
               for (int j = hit; j + 1 < shadow_len; j++) begin
                  shadow_ids[j] = shadow_ids[j + 1];
               end
               shadow_ids[IDX_W'(shadow_len - 1'b1)] = '0;
               shadow_len = shadow_len - 1'b1;
            end
         end
         default: begin
            for (int i = 0; i < CAPACITY; i++) begin
               shadow_ids[i] = '0;
            end
            shadow_len = '0;
         end
      endcase
      r.count = shadow_len;
   endtask

   initial begin
      fail_count    = 0;
      pending_count = 0;
      shadow_len    = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         shadow_ids[i] = '0;
      end
   end

   always @(posedge clock) begin
      list_rsp_type want;
      list_rsp_type got;
      if (reset) begin
         shadow_len = '0;
         awaited_rsp_q.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            apply_list_op(action_type'(req_tuser), req_tdata[31:0], req_tdata[39:32], want);
            awaited_rsp_q.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.id_out = rsp_tdata[31:0];
            got.count  = rsp_tdata[40:32];
            got.status = status_type'(rsp_tuser);
            if (awaited_rsp_q.size() == 0) begin
               $display("%0t: response beat with none expected: id_out %h count %0d status %0d",
                        $time, got.id_out, got.count, got.status);
               fail_count++;
            end else begin
               want = awaited_rsp_q.pop_front();
               if (got.id_out !== want.id_out) begin
                  $display("%0t: id_out mismatch: expected %h actual %h",
                           $time, want.id_out, got.id_out);
                  fail_count++;
               end
               if (got.count !== want.count) begin
                  $display("%0t: entry_count mismatch: expected %0d actual %0d",
                           $time, want.count, got.count);
                  fail_count++;
               end
               if (got.status !== want.status) begin
                  $display("%0t: status mismatch: expected %0d actual %0d",
                           $time, want.status, got.status);
                  fail_count++;
               end
            end
         end
      end
      pending_count = awaited_rsp_q.size();
   end

endmodule

### verif/packed_id_list_store_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Packed ID list store testbench
// Drives a short directed sequence of appends, reads, deletes and clears,
// then random phases that fill the list to capacity, drain it by deleting
// stored IDs, or mix all operations. Both streams see random gaps and
// stalls. The checker beside the block predicts and compares every beat.
// ----------------------------------------------------------------------------
module packed_id_list_store_top_tb;
   import pils_pkg::*;

   typedef enum logic [1:0] {
      PHASE_FILL,
      PHASE_DRAIN,
      PHASE_MIXED
   } phase_type;

   localparam int RANDOM_ITEMS = 1500;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   int          fail_count;
   int          pending_count;
   int          items_sent;
   int          stall_left;
   bit          req_calm;
   bit          rsp_calm;
   logic [31:0] id_pool [32];

   always #4 clock = ~clock;

   packed_id_list_store_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   list_store_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   function automatic int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [31:0] pick_id();
      if ($urandom_range(0, 99) < 80) begin
         return id_pool[$urandom_range(0, 31)];
      end
      return $urandom;
   endfunction

   function automatic logic [7:0] pick_index();
      if ($urandom_range(0, 1) == 0) begin
         return 8'($urandom_range(0, 15));
      end
      return 8'($urandom_range(0, 255));
   endfunction

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!rsp_calm && $urandom_range(0, 99) < 25) begin
         stall_left = gap_length();
         if (stall_left > 0) begin
            stall_left--;
         end
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Called at a falling edge; returns at a falling edge after the beat and any gap.
   task automatic issue(input action_type act, input logic [31:0] id,
                        input logic [7:0] idx);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {idx, id};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      @(negedge clock);
      items_sent++;
      gap = req_calm ? 0 : gap_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   initial begin
      #20000000;
      $display("FAIL");
      $finish;
   end

   initial begin
      phase_type   phase;
      int          phase_len;
      int          roll;
      int          phase_no;
      action_type  act;
      stall_left = 0;
      items_sent = 0;
      req_calm   = 1'b0;
      rsp_calm   = 1'b0;
      id_pool[0] = 32'h0000_0000;
      id_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < 32; i++) begin
         id_pool[i] = $urandom;
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      issue(ACT_READ,   32'hFFFF_FFFF, 8'h00);
      issue(ACT_DELETE, 32'h0000_0000, 8'hFF);
      issue(ACT_APPEND, 32'h0000_0000, 8'hFF);
      issue(ACT_APPEND, 32'hFFFF_FFFF, 8'h00);
      issue(ACT_APPEND, 32'h5A5A_A5A5, 8'h55);
      issue(ACT_APPEND, 32'hFFFF_FFFF, 8'hAA);
      issue(ACT_READ,   32'h0000_0000, 8'h00);
      issue(ACT_READ,   32'h0000_0000, 8'h01);
      issue(ACT_READ,   32'h0000_0000, 8'h03);
      issue(ACT_READ,   32'h0000_0000, 8'h04);
      issue(ACT_READ,   32'hFFFF_FFFF, 8'hFF);
      issue(ACT_DELETE, 32'hFFFF_FFFF, 8'h00);
      issue(ACT_READ,   32'h0000_0000, 8'h01);
      issue(ACT_READ,   32'h0000_0000, 8'h02);
      issue(ACT_DELETE, 32'h1234_5678, 8'h00);
      issue(ACT_DELETE, 32'h0000_0000, 8'h00);
      issue(ACT_CLEAR,  32'hFFFF_FFFF, 8'hFF);
      issue(ACT_READ,   32'h0000_0000, 8'h00);
      issue(ACT_APPEND, 32'hA5A5_5A5A, 8'h00);
      issue(ACT_DELETE, 32'hA5A5_5A5A, 8'h00);
      issue(ACT_CLEAR,  32'h0000_0000, 8'h00);

      phase_no   = 0;
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         phase     = (phase_no == 0) ? PHASE_FILL : phase_type'($urandom_range(0, 2));
         phase_len = (phase == PHASE_FILL) ? $urandom_range(300, 450) : $urandom_range(100, 300);
         req_calm  = ($urandom_range(0, 3) == 0);
         rsp_calm  = ($urandom_range(0, 3) == 0);
         phase_no++;
         for (int n = 0; n < phase_len && items_sent < RANDOM_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            case (phase)
               PHASE_FILL:  act = (roll < 85) ? ACT_APPEND : (roll < 95) ? ACT_READ : ACT_DELETE;
               PHASE_DRAIN: act = (roll < 15) ? ACT_APPEND : (roll < 35) ? ACT_READ :
                                  (roll < 98) ? ACT_DELETE : ACT_CLEAR;
               default:     act = (roll < 40) ? ACT_APPEND : (roll < 65) ? ACT_READ :
                                  (roll < 98) ? ACT_DELETE : ACT_CLEAR;
            endcase
            issue(act, pick_id(), pick_index());
         end
      end
      req_tvalid <= 1'b0;
      rsp_calm = 1'b0;

      while (pending_count != 0) begin
         @(posedge clock);
      end
      repeat (300) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### files.f
rtl/pils_pkg.sv
rtl/pils_cell.sv
rtl/pils_ctrl.sv
rtl/packed_id_list_store_top.sv
verif/list_store_checker.sv
verif/packed_id_list_store_top_tb.sv
